FILE: sv/wilder_rsi_defines.svh
// Assertion macros for the Wilder RSI block.
// Taken in by the modules that check their own logic; no other dependencies.
`ifndef WILDER_RSI_DEFINES_SVH
`define WILDER_RSI_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge, quiet while reset is held.
`define WRSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define WRSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WRSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define WRSI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/wrsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Wilder RSI block.
// No dependencies; used by wrsi_outreg and wilder_rsi.
package wrsi_pkg;

  localparam int unsigned PRICE_W        = 32;  // close price port width
  localparam int unsigned RSI_W          = 23;  // rsi value port width
  localparam int unsigned PERIOD_W       = 7;
  localparam int unsigned MAX_PERIOD_DEF = 64;
  localparam int unsigned PRICE_BITS_DEF = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 7'd2;
  localparam logic [PERIOD_W-1:0] SEEDED_MARK  = 7'h7F;

  localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;  // 100.0
  localparam logic [RSI_W-1:0] RSI_HALF = 23'd3276800;  // 50.0

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOADG,
    ST_LOADL,
    ST_DIV,
    ST_CHECK,
    ST_RATIO,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             ready;
    logic             zero_loss;
  } res_t;

endpackage

FILE: sv/wilder_rsi.sv
`timescale 1ns / 1ps
// Top level of the Wilder RSI block: sequencer, state and datapath.
// Depends on wrsi_pkg, wrsi_cmpsub, wrsi_outreg and wilder_rsi_defines.svh.
//
//   channel   direction  handshake                payload
//   -------   ---------  -----------------------  ------------------------------------
//   input     in         in_valid_i / in_stall_o  close_price_i
//   output    out        out_valid_o/out_stall_i  rsi_value_o, ready_res_o, zero_loss_o
//   config    in         cfg_we_i                 cfg_wdata_i (period)
//
// A bar that updates the averages runs two divisions by the period and a 23-digit ratio
// through the one compare-subtract unit; the next bar is taken once the sequencer is back
// in idle. A zero loss average skips the ratio; a bar before seeding skips the divisions
// and the ratio.
// Reset clears the period to 14 and all running state; no clearing pass is needed.
// The input stalls while a bar is worked on; a result waits in the output register, so the
// next bar is accepted while that result is still stalled.
`include "wilder_rsi_defines.svh"

module wilder_rsi #(
  parameter int unsigned MAX_PERIOD = wrsi_pkg::MAX_PERIOD_DEF,
  parameter int unsigned PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // bar input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wrsi_pkg::PRICE_W-1:0]  close_price_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wrsi_pkg::RSI_W-1:0]    rsi_value_o,
  output logic                          ready_res_o,
  output logic                          zero_loss_o,
  // period register
  input  logic                          cfg_we_i,
  input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_wdata_i
);

  // Averages carry six bits of headroom for the seed sums.
  localparam int unsigned AVG_BITS = PRICE_BITS + 6;
  // Smoothing dividend avg*(p-1)+x needs seven more bits plus a carry.
  localparam int unsigned DW       = AVG_BITS + 8;
  // Shared unit width: remainder of the ratio can reach twice gain+loss.
  localparam int unsigned UW       = AVG_BITS + 2;
  localparam int unsigned CW       = $clog2(DW);
  localparam int unsigned BW       = $clog2(wrsi_pkg::RSI_W);
  localparam int unsigned PW       = wrsi_pkg::PERIOD_W;
  localparam logic [PW-1:0] PCAP   = PW'((MAX_PERIOD > 127) ? 127 : MAX_PERIOD);

  wrsi_pkg::state_e state_q, state_d;

  // Running state.
  logic [PW-1:0]         period_q;
  logic [PRICE_BITS-1:0] last_q;
  logic                  have_last_q;
  logic [PW-1:0]         diff_q;
  logic [AVG_BITS-1:0]   gain_q;
  logic [AVG_BITS-1:0]   loss_q;

  // Sequencer control.
  logic          smooth_q;
  logic          sel_loss_q;
  logic [CW-1:0] cnt_q;
  logic          phase_q;

  // Per-bar working registers.
  logic [PRICE_BITS-1:0]      cur_q;
  logic [PRICE_BITS-1:0]      g_q;
  logic [PRICE_BITS-1:0]      l_q;
  logic [DW-1:0]              dvd_q;
  logic [UW-1:0]              rem_q;
  logic [wrsi_pkg::RSI_W-1:0] q_q;
  logic [BW-1:0]              bit_q;
  wrsi_pkg::res_t             res_q;

  logic [PRICE_BITS-1:0] price_in;
  logic [PW-1:0]         p_eff;
  logic [PW-1:0]         pm1;
  logic [PRICE_BITS-1:0] g_c;
  logic [PRICE_BITS-1:0] l_c;
  logic [AVG_BITS:0]     gsum_w;
  logic [AVG_BITS:0]     lsum_w;
  logic [AVG_BITS-1:0]   gsum;
  logic [AVG_BITS-1:0]   lsum;
  logic                  seed_end;
  logic [AVG_BITS-1:0]   mul_avg;
  logic [PRICE_BITS-1:0] mul_x;
  logic [AVG_BITS+6:0]   mul_prod;
  logic [DW-1:0]         dvd_load;
  logic [UW-1:0]         unit_r;
  logic [UW-1:0]         unit_den;
  logic [UW-1:0]         unit_r_out;
  logic                  unit_ge;
  logic [DW-1:0]         quot;
  logic                  div_last;
  logic                  res_load;
  logic                  out_free;
  wrsi_pkg::res_t        out_res;

  // Keep the low PRICE_BITS of the close, zero-extend when the price is wider.
  if (PRICE_BITS <= wrsi_pkg::PRICE_W) begin : g_price_trunc
    assign price_in = close_price_i[PRICE_BITS-1:0];
  end else begin : g_price_ext
    assign price_in = {{(PRICE_BITS - wrsi_pkg::PRICE_W){1'b0}}, close_price_i};
  end

  // Clamp the period into [2, MAX_PERIOD], with MAX_PERIOD capped at 127.
  assign p_eff = (period_q < wrsi_pkg::PERIOD_MIN) ? wrsi_pkg::PERIOD_MIN :
                 (period_q > PCAP) ? PCAP : period_q;
  assign pm1   = p_eff - PW'(1);

  // Split the bar's move into gain and loss.
  assign g_c = (cur_q > last_q) ? (cur_q - last_q) : '0;
  assign l_c = (cur_q < last_q) ? (last_q - cur_q) : '0;

  // Seed sums saturate at all ones.
  assign gsum_w = {1'b0, gain_q} + (AVG_BITS+1)'(g_c);
  assign lsum_w = {1'b0, loss_q} + (AVG_BITS+1)'(l_c);
  assign gsum   = gsum_w[AVG_BITS] ? '1 : gsum_w[AVG_BITS-1:0];
  assign lsum   = lsum_w[AVG_BITS] ? '1 : lsum_w[AVG_BITS-1:0];

  assign seed_end = ({1'b0, diff_q} + (PW+1)'(1)) >= {1'b0, p_eff};

  // One multiplier, shared between the gain and the loss dividend.
  assign mul_avg  = (state_q == wrsi_pkg::ST_LOADL) ? loss_q : gain_q;
  assign mul_x    = (state_q == wrsi_pkg::ST_LOADL) ? l_q : g_q;
  assign mul_prod = (AVG_BITS+7)'(mul_avg) * (AVG_BITS+7)'(pm1);
  assign dvd_load = smooth_q ? (DW'(mul_prod) + DW'(mul_x)) : DW'(mul_avg);

  // Operand select for the shared compare-subtract unit.
  always_comb begin
    unit_den = UW'(gain_q) + UW'(loss_q);
    unit_r   = rem_q;
    if (state_q == wrsi_pkg::ST_DIV) begin
      unit_den = UW'(p_eff);
      unit_r   = {rem_q[UW-2:0], dvd_q[DW-1]};
    end else if (state_q == wrsi_pkg::ST_RATIO) begin
      if (!phase_q) begin
        unit_r = {rem_q[UW-2:0], 1'b0};
      end else if (wrsi_pkg::RSI_FULL[bit_q]) begin
        unit_r = rem_q + UW'(gain_q);
      end
    end
  end

  wrsi_cmpsub #(
    .W (UW)
  ) u_cmpsub (
    .r_i   (unit_r),
    .den_i (unit_den),
    .r_o   (unit_r_out),
    .ge_o  (unit_ge)
  );

  assign quot     = {dvd_q[DW-2:0], unit_ge};
  assign div_last = (cnt_q == CW'(DW - 1));

  // Next state.
  always_comb begin
    state_d  = state_q;
    res_load = 1'b0;
    unique case (state_q)
      wrsi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = wrsi_pkg::ST_CALC;
        end
      end
      wrsi_pkg::ST_CALC: begin
        if (have_last_q && ((diff_q == wrsi_pkg::SEEDED_MARK) || seed_end)) begin
          state_d = wrsi_pkg::ST_LOADG;
        end else begin
          state_d = wrsi_pkg::ST_FIN;
        end
      end
      wrsi_pkg::ST_LOADG,
      wrsi_pkg::ST_LOADL: begin
        state_d = wrsi_pkg::ST_DIV;
      end
      wrsi_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = sel_loss_q ? wrsi_pkg::ST_CHECK : wrsi_pkg::ST_LOADL;
        end
      end
      wrsi_pkg::ST_CHECK: begin
        state_d = (loss_q == '0) ? wrsi_pkg::ST_FIN : wrsi_pkg::ST_RATIO;
      end
      wrsi_pkg::ST_RATIO: begin
        if (phase_q && (bit_q == '0)) begin
          state_d = wrsi_pkg::ST_FIN;
        end
      end
      wrsi_pkg::ST_FIN: begin
        // Hand the result over as soon as the output slot is free.
        if (out_free) begin
          res_load = 1'b1;
          state_d  = wrsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrsi_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != wrsi_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Running state and sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= wrsi_pkg::PERIOD_RESET;
      last_q      <= '0;
      have_last_q <= 1'b0;
      diff_q      <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      smooth_q    <= 1'b0;
      sel_loss_q  <= 1'b0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      unique case (state_q)
        wrsi_pkg::ST_CALC: begin
          last_q      <= cur_q;
          have_last_q <= 1'b1;
          if (have_last_q) begin
            if (diff_q == wrsi_pkg::SEEDED_MARK) begin
              smooth_q <= 1'b1;
            end else begin
              // Accumulate the seed window; close it once p differences are in.
              gain_q   <= gsum;
              loss_q   <= lsum;
              smooth_q <= 1'b0;
              diff_q   <= seed_end ? wrsi_pkg::SEEDED_MARK : (diff_q + PW'(1));
            end
          end
        end
        wrsi_pkg::ST_LOADG: begin
          sel_loss_q <= 1'b0;
          cnt_q      <= '0;
        end
        wrsi_pkg::ST_LOADL: begin
          sel_loss_q <= 1'b1;
          cnt_q      <= '0;
        end
        wrsi_pkg::ST_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (div_last) begin
            if (sel_loss_q) begin
              loss_q <= quot[AVG_BITS-1:0];
            end else begin
              gain_q <= quot[AVG_BITS-1:0];
            end
          end
        end
        wrsi_pkg::ST_CHECK: begin
          phase_q <= 1'b0;
        end
        wrsi_pkg::ST_RATIO: begin
          phase_q <= !phase_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current bar.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      wrsi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cur_q <= price_in;
        end
      end
      wrsi_pkg::ST_CALC: begin
        g_q   <= g_c;
        l_q   <= l_c;
        res_q <= '0;
      end
      wrsi_pkg::ST_LOADG,
      wrsi_pkg::ST_LOADL: begin
        dvd_q <= dvd_load;
        rem_q <= '0;
      end
      wrsi_pkg::ST_DIV: begin
        // Restoring division: shift a dividend bit in, quotient bits fill from below.
        rem_q <= unit_r_out;
        dvd_q <= quot;
      end
      wrsi_pkg::ST_CHECK: begin
        rem_q           <= '0;
        q_q             <= '0;
        bit_q           <= BW'(wrsi_pkg::RSI_W - 1);
        res_q.ready     <= 1'b1;
        res_q.zero_loss <= (loss_q == '0);
        if (loss_q != '0) begin
          res_q.rsi <= '0;
        end else if (gain_q == '0) begin
          res_q.rsi <= wrsi_pkg::RSI_HALF;
        end else begin
          res_q.rsi <= wrsi_pkg::RSI_FULL;
        end
      end
      wrsi_pkg::ST_RATIO: begin
        // Two half steps per digit of 100.0: double, then add gain where the digit is set.
        rem_q <= unit_r_out;
        if (!phase_q) begin
          q_q <= {q_q[wrsi_pkg::RSI_W-2:0], 1'b0} + {{(wrsi_pkg::RSI_W-1){1'b0}}, unit_ge};
        end else begin
          q_q <= q_q + {{(wrsi_pkg::RSI_W-1){1'b0}}, unit_ge};
          if (bit_q == '0) begin
            res_q.rsi <= q_q + {{(wrsi_pkg::RSI_W-1){1'b0}}, unit_ge};
          end else begin
            bit_q <= bit_q - BW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  wrsi_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res_q),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (out_res),
    .free_o  (out_free)
  );

  assign rsi_value_o = out_res.rsi;
  assign ready_res_o = out_res.ready;
  assign zero_loss_o = out_res.zero_loss;

  `WRSI_ASSERT(a_accept_to_calc, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == wrsi_pkg::ST_CALC), "accepted bar not taken into calc")
  `WRSI_ASSERT(a_div_count, clk_i, rst_ni, (state_q == wrsi_pkg::ST_DIV) |-> (cnt_q < CW'(DW)), "division step count overrun")
  `WRSI_ASSERT(a_ready_seeded, clk_i, rst_ni, (res_load && res_q.ready) |-> (diff_q == wrsi_pkg::SEEDED_MARK), "ready result before seeding")

endmodule

FILE: sv/wrsi_cmpsub.sv
`timescale 1ns / 1ps
// Shared compare-and-subtract step used for every division and the ratio.
// No dependencies.
module wrsi_cmpsub #(
  parameter int unsigned W = 40
) (
  input  logic [W-1:0] r_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] r_o,
  output logic         ge_o
);

  assign ge_o = (r_i >= den_i);
  assign r_o  = ge_o ? (r_i - den_i) : r_i;

endmodule

FILE: sv/wrsi_outreg.sv
`timescale 1ns / 1ps
// Output holding register of the Wilder RSI block: one result slot.
// Depends on wrsi_pkg and wilder_rsi_defines.svh.
`include "wilder_rsi_defines.svh"

module wrsi_outreg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  wrsi_pkg::res_t res_i,
  input  logic          stall_i,
  output logic          valid_o,
  output wrsi_pkg::res_t res_o,
  output logic          free_o
);

  logic           valid_q;
  wrsi_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign free_o  = !valid_q || !stall_i;

  `WRSI_ASSERT(a_zl_forced, clk_i, rst_ni, (valid_q && res_q.zero_loss) |-> ((res_q.rsi == wrsi_pkg::RSI_FULL) || (res_q.rsi == wrsi_pkg::RSI_HALF)), "zero loss result without forced rsi")
  `WRSI_ASSERT(a_notready_zero, clk_i, rst_ni, (valid_q && !res_q.ready) |-> ((res_q.rsi == '0) && !res_q.zero_loss), "unseeded result carries data")
  `WRSI_ASSERT(a_rsi_range, clk_i, rst_ni, valid_q |-> (res_q.rsi <= wrsi_pkg::RSI_FULL), "rsi above full scale")

endmodule
